### rtl/core/ggs_pkg.sv
// Shared constants, codes and control types of the generation-step core.
`timescale 1ns / 1ps

package ggs_pkg;

    localparam int POP_SIZE   = 64;
    localparam int CHROM_BITS = 16;
    localparam int FIT_BITS   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int TOTAL_W    = 22;
    localparam int SLOT_W     = $clog2(POP_SIZE);
    localparam int CNT_W      = $clog2(POP_SIZE + 1);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int THR_W      = 16;
    localparam int PCNT_W     = 7;
    localparam int PROD_W     = TOTAL_W + FRAC_BITS;

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(45875);
    localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(50);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_FITNESS = 2'd1,
        MODE_BREED   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic {
        REG_XOVER_THR = 1'b0,
        REG_POP_COUNT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_PAR_I,
        WR_PAR_J,
        WR_NEXT0,
        WR_NEXT1
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT_A,
        ST_TGT_B,
        ST_WALK,
        ST_RD_I,
        ST_RD_J,
        ST_CALC,
        ST_WR_PI,
        ST_WR_PJ,
        ST_WR_N0,
        ST_WR_N1,
        ST_EMIT0,
        ST_EMIT1
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    mul_en;
        logic    mul_b;
        logic    walk_start;
        logic    rd_j;
        logic    latch_gi;
        logic    calc;
        wr_sel_t wr_sel;
        logic    load_beat;
        logic    beat_last;
    } cmd_t;

    typedef struct packed {
        logic walk_busy;
        logic out_free;
    } status_t;

endpackage

### rtl/core/genetic_generation_step_core.sv
// Top level of the generation-step core: configuration registers and core wiring.
// Loads (mode 0) and fitness writes (mode 1) are taken in the idle state and leave
// the core idle. A breed beat (mode 2) holds off the next input beat until its whole
// sequence is done: two multiplies, the single pass over the first n entries of the
// fitness memory (n the effective population size, pop_count forced even, 2 to 64),
// one entry per cycle, that serves both roulette picks, two population reads, one
// crossover step, four population writes through the one write port and the two
// result beats. The second result beat may wait in the output register while the next
// input beat is taken. Mode 3 beats are taken and dropped. The stores hold no reset
// value: read only entries that have been written.
`timescale 1ns / 1ps

module genetic_generation_step_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ggs_pkg::PADDR_W-1:0]        paddr,
    input  logic [ggs_pkg::PDATA_W-1:0]        pwdata,
    output logic [ggs_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_mode,
    input  logic [ggs_pkg::SLOT_W-1:0]         s_slot,
    input  logic [ggs_pkg::CHROM_BITS-1:0]     s_genes,
    input  logic [ggs_pkg::FIT_BITS-1:0]       s_fitness_value,
    input  logic [ggs_pkg::FRAC_BITS-1:0]      s_slice_a,
    input  logic [ggs_pkg::FRAC_BITS-1:0]      s_slice_b,
    input  logic [ggs_pkg::FRAC_BITS-1:0]      s_cross_draw,
    input  logic [3:0]                         s_cross_point,
    input  logic [ggs_pkg::CHROM_BITS-1:0]     s_flip_mask_a,
    input  logic [ggs_pkg::CHROM_BITS-1:0]     s_flip_mask_b,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ggs_pkg::SLOT_W-1:0]         m_child_position,
    output logic [ggs_pkg::CHROM_BITS-1:0]     m_child_genes,
    output logic [ggs_pkg::SLOT_W-1:0]         m_parent_slot,
    output logic                               m_last,
    output logic                               m_generation_done
);

    logic [ggs_pkg::THR_W-1:0]  thr_reg;
    logic [ggs_pkg::PCNT_W-1:0] pcnt_reg;
    ggs_pkg::reg_idx_t          reg_idx;
    ggs_pkg::cmd_t              cmd;
    ggs_pkg::status_t           status;

    assign pready  = 1'b1;
    assign reg_idx = ggs_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= ggs_pkg::THR_RESET;
            pcnt_reg <= ggs_pkg::PCNT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                ggs_pkg::REG_XOVER_THR: thr_reg  <= pwdata[ggs_pkg::THR_W-1:0];
                ggs_pkg::REG_POP_COUNT: pcnt_reg <= pwdata[ggs_pkg::PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ggs_pkg::REG_XOVER_THR: prdata = ggs_pkg::PDATA_W'(thr_reg);
            ggs_pkg::REG_POP_COUNT: prdata = ggs_pkg::PDATA_W'(pcnt_reg);
            default:                prdata = '0;
        endcase
    end

    ggs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .status  (status),
        .cmd     (cmd)
    );

    ggs_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .xover_thr         (thr_reg),
        .pop_count         (pcnt_reg),
        .s_mode            (s_mode),
        .s_slot            (s_slot),
        .s_genes           (s_genes),
        .s_fitness_value   (s_fitness_value),
        .s_slice_a         (s_slice_a),
        .s_slice_b         (s_slice_b),
        .s_cross_draw      (s_cross_draw),
        .s_cross_point     (s_cross_point),
        .s_flip_mask_a     (s_flip_mask_a),
        .s_flip_mask_b     (s_flip_mask_b),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_child_position  (m_child_position),
        .m_child_genes     (m_child_genes),
        .m_parent_slot     (m_parent_slot),
        .m_last            (m_last),
        .m_generation_done (m_generation_done)
    );

endmodule

### rtl/core/ggs_ctrl.sv
// Sequencer of the generation-step core: accepts beats and steps the breed sequence.
`timescale 1ns / 1ps

module ggs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_mode,
    input  ggs_pkg::status_t status,
    output ggs_pkg::cmd_t    cmd
);

    ggs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ggs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ggs_pkg::ST_IDLE: begin
                if (s_valid && (s_mode == ggs_pkg::MODE_BREED)) begin
                    state_next = ggs_pkg::ST_TGT_A;
                end
            end
            ggs_pkg::ST_TGT_A: state_next = ggs_pkg::ST_TGT_B;
            ggs_pkg::ST_TGT_B: state_next = ggs_pkg::ST_WALK;
            ggs_pkg::ST_WALK: begin
                if (!status.walk_busy) begin
                    state_next = ggs_pkg::ST_RD_I;
                end
            end
            ggs_pkg::ST_RD_I:  state_next = ggs_pkg::ST_RD_J;
            ggs_pkg::ST_RD_J:  state_next = ggs_pkg::ST_CALC;
            ggs_pkg::ST_CALC:  state_next = ggs_pkg::ST_WR_PI;
            ggs_pkg::ST_WR_PI: state_next = ggs_pkg::ST_WR_PJ;
            ggs_pkg::ST_WR_PJ: state_next = ggs_pkg::ST_WR_N0;
            ggs_pkg::ST_WR_N0: state_next = ggs_pkg::ST_WR_N1;
            ggs_pkg::ST_WR_N1: state_next = ggs_pkg::ST_EMIT0;
            ggs_pkg::ST_EMIT0: begin
                if (status.out_free) begin
                    state_next = ggs_pkg::ST_EMIT1;
                end
            end
            ggs_pkg::ST_EMIT1: begin
                if (status.out_free) begin
                    state_next = ggs_pkg::ST_IDLE;
                end
            end
            default: state_next = ggs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ggs_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ggs_pkg::ST_TGT_A: cmd.mul_en = 1'b1;
            ggs_pkg::ST_TGT_B: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_b      = 1'b1;
                cmd.walk_start = 1'b1;
            end
            ggs_pkg::ST_WALK:  ;
            ggs_pkg::ST_RD_I:  ;
            ggs_pkg::ST_RD_J: begin
                cmd.rd_j     = 1'b1;
                cmd.latch_gi = 1'b1;
            end
            ggs_pkg::ST_CALC:  cmd.calc   = 1'b1;
            ggs_pkg::ST_WR_PI: cmd.wr_sel = ggs_pkg::WR_PAR_I;
            ggs_pkg::ST_WR_PJ: cmd.wr_sel = ggs_pkg::WR_PAR_J;
            ggs_pkg::ST_WR_N0: cmd.wr_sel = ggs_pkg::WR_NEXT0;
            ggs_pkg::ST_WR_N1: cmd.wr_sel = ggs_pkg::WR_NEXT1;
            ggs_pkg::ST_EMIT0: cmd.load_beat = status.out_free;
            ggs_pkg::ST_EMIT1: begin
                cmd.load_beat = status.out_free;
                cmd.beat_last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/ggs_datapath.sv
// Datapath of the generation-step core: stores, roulette walk, crossover and output beat.
`timescale 1ns / 1ps

module ggs_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ggs_pkg::cmd_t                      cmd,
    output ggs_pkg::status_t                   status,
    input  logic [ggs_pkg::THR_W-1:0]          xover_thr,
    input  logic [ggs_pkg::PCNT_W-1:0]         pop_count,
    input  logic [1:0]                         s_mode,
    input  logic [ggs_pkg::SLOT_W-1:0]         s_slot,
    input  logic [ggs_pkg::CHROM_BITS-1:0]     s_genes,
    input  logic [ggs_pkg::FIT_BITS-1:0]       s_fitness_value,
    input  logic [ggs_pkg::FRAC_BITS-1:0]      s_slice_a,
    input  logic [ggs_pkg::FRAC_BITS-1:0]      s_slice_b,
    input  logic [ggs_pkg::FRAC_BITS-1:0]      s_cross_draw,
    input  logic [3:0]                         s_cross_point,
    input  logic [ggs_pkg::CHROM_BITS-1:0]     s_flip_mask_a,
    input  logic [ggs_pkg::CHROM_BITS-1:0]     s_flip_mask_b,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ggs_pkg::SLOT_W-1:0]         m_child_position,
    output logic [ggs_pkg::CHROM_BITS-1:0]     m_child_genes,
    output logic [ggs_pkg::SLOT_W-1:0]         m_parent_slot,
    output logic                               m_last,
    output logic                               m_generation_done
);

    localparam int CW = ggs_pkg::CHROM_BITS;
    localparam int SW = ggs_pkg::SLOT_W;
    localparam int TW = ggs_pkg::TOTAL_W;

    logic [CW-1:0] pop_mem [2*ggs_pkg::POP_SIZE];
    logic [ggs_pkg::FIT_BITS-1:0] fit_mem [ggs_pkg::POP_SIZE];

    logic [ggs_pkg::FRAC_BITS-1:0] slice_a_reg, slice_b_reg, draw_reg;
    logic [3:0]                    cp_reg;
    logic [CW-1:0]                 mask_a_reg, mask_b_reg;

    logic [TW-1:0]             total_reg;
    logic [ggs_pkg::CNT_W-1:0] fill_reg;
    logic                      bank_reg;

    logic [ggs_pkg::PROD_W-1:0] tgt_a_reg, tgt_b_reg, prod;

    logic                      issue_reg, q_vld_reg;
    logic [ggs_pkg::CNT_W-1:0] rd_cnt_reg;
    logic [SW-1:0]             q_idx_reg;
    logic [ggs_pkg::FIT_BITS-1:0] fit_q_reg;
    logic [TW-1:0]             cum_reg, cum_sum;
    logic                      found_a_reg, found_b_reg, hit_a, hit_b;
    logic [SW-1:0]             pi_reg, pj_reg;

    logic [CW-1:0] pop_q_reg, gi_reg, c1_reg, c2_reg, keep, x1, x2;
    logic          do_cross;

    logic [ggs_pkg::CNT_W-1:0] n_clamp, n_eff, fill_inc;
    logic                      done;
    logic [TW:0]               total_sum;

    logic          we;
    logic [SW:0]   waddr, raddr;
    logic [CW-1:0] wdata;

    logic out_vld_reg;

    always_comb begin
        if (pop_count < ggs_pkg::CNT_W'(2)) begin
            n_clamp = ggs_pkg::CNT_W'(2);
        end else if (pop_count > ggs_pkg::CNT_W'(ggs_pkg::POP_SIZE)) begin
            n_clamp = ggs_pkg::CNT_W'(ggs_pkg::POP_SIZE);
        end else begin
            n_clamp = pop_count;
        end
        n_eff = {n_clamp[ggs_pkg::CNT_W-1:1], 1'b0};
    end

    assign fill_inc = fill_reg + ggs_pkg::CNT_W'(2);
    assign done     = (fill_inc >= n_eff);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            slice_a_reg <= s_slice_a;
            slice_b_reg <= s_slice_b;
            draw_reg    <= s_cross_draw;
            cp_reg      <= s_cross_point;
            mask_a_reg  <= s_flip_mask_a;
            mask_b_reg  <= s_flip_mask_b;
        end
    end

    assign total_sum = {1'b0, total_reg} + (TW + 1)'(s_fitness_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
        end else if (cmd.accept && (s_mode == ggs_pkg::MODE_FITNESS)) begin
            total_reg <= total_sum[TW] ? ggs_pkg::TOTAL_MAX : total_sum[TW-1:0];
        end else if (cmd.load_beat && cmd.beat_last) begin
            if (done) begin
                total_reg <= '0;
                fill_reg  <= '0;
                bank_reg  <= ~bank_reg;
            end else begin
                fill_reg  <= fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_mode == ggs_pkg::MODE_FITNESS)) begin
            fit_mem[s_slot] <= s_fitness_value;
        end
        fit_q_reg <= fit_mem[rd_cnt_reg[SW-1:0]];
    end

    assign prod = ggs_pkg::PROD_W'(cmd.mul_b ? slice_b_reg : slice_a_reg)
                * ggs_pkg::PROD_W'(total_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            if (cmd.mul_b) begin
                tgt_b_reg <= prod;
            end else begin
                tgt_a_reg <= prod;
            end
        end
    end

    assign cum_sum = cum_reg + TW'(fit_q_reg);
    assign hit_a   = ({cum_sum, {ggs_pkg::FRAC_BITS{1'b0}}} >= tgt_a_reg);
    assign hit_b   = ({cum_sum, {ggs_pkg::FRAC_BITS{1'b0}}} >= tgt_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg   <= 1'b0;
            q_vld_reg   <= 1'b0;
            rd_cnt_reg  <= '0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
        end else if (cmd.walk_start) begin
            issue_reg   <= 1'b1;
            q_vld_reg   <= 1'b0;
            rd_cnt_reg  <= '0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
        end else begin
            q_vld_reg <= issue_reg;
            if (issue_reg) begin
                q_idx_reg  <= rd_cnt_reg[SW-1:0];
                rd_cnt_reg <= rd_cnt_reg + ggs_pkg::CNT_W'(1);
                if (rd_cnt_reg + ggs_pkg::CNT_W'(1) == n_eff) begin
                    issue_reg <= 1'b0;
                end
            end
            if (q_vld_reg) begin
                if (!found_a_reg && hit_a) begin
                    found_a_reg <= 1'b1;
                end
                if (!found_b_reg && hit_b) begin
                    found_b_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            cum_reg <= '0;
            pi_reg  <= SW'(n_eff - ggs_pkg::CNT_W'(1));
            pj_reg  <= SW'(n_eff - ggs_pkg::CNT_W'(1));
        end else if (q_vld_reg) begin
            cum_reg <= cum_sum;
            if (!found_a_reg && hit_a) begin
                pi_reg <= q_idx_reg;
            end
            if (!found_b_reg && hit_b) begin
                pj_reg <= q_idx_reg;
            end
        end
    end

    assign status.walk_busy = issue_reg | q_vld_reg;

    assign raddr = {bank_reg, cmd.rd_j ? pj_reg : pi_reg};

    always_comb begin
        we    = 1'b1;
        waddr = {bank_reg, pi_reg};
        wdata = c1_reg;
        unique case (cmd.wr_sel)
            ggs_pkg::WR_PAR_I: ;
            ggs_pkg::WR_PAR_J: begin
                waddr = {bank_reg, pj_reg};
                wdata = c2_reg;
            end
            ggs_pkg::WR_NEXT0: waddr = {~bank_reg, fill_reg[SW-1:0]};
            ggs_pkg::WR_NEXT1: begin
                waddr = {~bank_reg, fill_reg[SW-1:0] + SW'(1)};
                wdata = c2_reg;
            end
            default: begin
                we    = cmd.accept && (s_mode == ggs_pkg::MODE_LOAD);
                waddr = {bank_reg, s_slot};
                wdata = s_genes;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            pop_mem[waddr] <= wdata;
        end
        pop_q_reg <= pop_mem[raddr];
    end

    assign do_cross = (draw_reg < xover_thr);
    assign keep     = ~({CW{1'b1}} >> cp_reg);
    assign x1       = do_cross ? ((gi_reg & keep) | (pop_q_reg & ~keep)) : gi_reg;
    assign x2       = do_cross ? ((pop_q_reg & keep) | (gi_reg & ~keep)) : pop_q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_gi) begin
            gi_reg <= pop_q_reg;
        end
        if (cmd.calc) begin
            if (pi_reg == pj_reg) begin
                c1_reg <= gi_reg ^ mask_a_reg ^ mask_b_reg;
                c2_reg <= gi_reg ^ mask_a_reg ^ mask_b_reg;
            end else begin
                c1_reg <= x1 ^ mask_a_reg;
                c2_reg <= x2 ^ mask_b_reg;
            end
        end
    end

    assign status.out_free = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_beat) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_beat) begin
            m_child_position  <= fill_reg[SW-1:0] + SW'(cmd.beat_last);
            m_child_genes     <= cmd.beat_last ? c2_reg : c1_reg;
            m_parent_slot     <= cmd.beat_last ? pj_reg : pi_reg;
            m_last            <= cmd.beat_last;
            m_generation_done <= done;
        end
    end

    assign m_valid = out_vld_reg;

endmodule

### rtl/core/ggs_checker.sv
// Port-level checker of the generation-step core and its bind to the top level.
`timescale 1ns / 1ps

module ggs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [ggs_pkg::SLOT_W-1:0]     m_child_position,
    input logic [ggs_pkg::CHROM_BITS-1:0] m_child_genes,
    input logic [ggs_pkg::SLOT_W-1:0]     m_parent_slot,
    input logic                           m_last,
    input logic                           m_generation_done
);

    logic                         expect_last_reg;
    logic [ggs_pkg::SLOT_W-1:0]   first_pos_reg;
    logic                         first_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_last_reg <= 1'b0;
            first_pos_reg   <= '0;
            first_done_reg  <= 1'b0;
        end else if (m_valid && m_ready) begin
            expect_last_reg <= !m_last;
            first_pos_reg   <= m_child_position;
            first_done_reg  <= m_generation_done;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_child_genes)
            && $stable(m_parent_slot) && $stable(m_child_position))
        else $error("result beat changed while stalled");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> m_last == expect_last_reg)
        else $error("result beats not in first/second pairs");

    a_pair_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last
            |-> m_child_position == first_pos_reg + ggs_pkg::SLOT_W'(1))
        else $error("second child position does not follow the first");

    a_pair_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |-> m_generation_done == first_done_reg)
        else $error("generation_done differs within a pair");

endmodule

bind genetic_generation_step_core ggs_checker u_ggs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_child_position  (m_child_position),
    .m_child_genes     (m_child_genes),
    .m_parent_slot     (m_parent_slot),
    .m_last            (m_last),
    .m_generation_done (m_generation_done)
);
